FILE: src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg: shared types and constants for the text console cursor writer
// Request and result layouts, operation codes and default screen geometry.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry
  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;
  localparam int TAB_DEFAULT  = 8;

  // Control characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_TAB     = 8'd9;

  // Operation codes
  typedef enum logic [0:0] {
    OP_PUT_CHAR   = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_t;

  // One request
  typedef struct packed {
    op_t        operation;
    logic [7:0] character;
    logic [7:0] attribute;
    logic [6:0] new_column;
    logic [4:0] new_row;
  } request_t;

  // One result
  typedef struct packed {
    logic        write_enable;
    logic [10:0] cell_address;
    logic [15:0] cell_value;
    logic        scroll_request;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } result_t;

endpackage

FILE: src/tccw_stream_if.sv
// ----------------------------------------------------------------------------
// tccw_stream_if: valid/ready channel
// Carries one payload per request; accepted when valid and ready are high.
// ----------------------------------------------------------------------------
interface tccw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer: cursor tracking and cell-write generation
// Keeps the cursor of a COLS x ROWS text screen, turns characters into
// 16-bit cell writes and flags a scroll when the screen end is passed.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload          | handshake
//  ---------+-----+------------------+-------------
//  item     | in  | tccw_pkg::request_t | valid/ready
//  result   | out | tccw_pkg::result_t  | valid/ready
//
// One request per clock while the result is not stalled; its result is registered and shows in the cycle after.
// The cursor update (one constant multiply, small wrap logic) and the write decode
// are the only logic between the request and the result register.
// A request is taken while a result waits if that result leaves the same cycle.
// Synchronous reset puts the cursor at cell 0 and empties the result register.
// A stalled result holds its value; no request is taken until room exists.
module text_console_cursor_writer #(
  parameter int COLS = tccw_pkg::COLS_DEFAULT,
  parameter int ROWS = tccw_pkg::ROWS_DEFAULT,
  parameter int TAB  = tccw_pkg::TAB_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  tccw_stream_if.sink   item,
  tccw_stream_if.source result
);

  localparam int CW         = $clog2(COLS);
  localparam int RW         = $clog2(ROWS);
  localparam int PW         = $clog2(COLS * ROWS);
  localparam int CSW        = $clog2(COLS + TAB);
  localparam int WRAPS      = (COLS - 1 + TAB) / COLS;
  localparam int LAST_START = COLS * (ROWS - 1);

  // Cursor state
  logic [CW-1:0] column_now, column_next;
  logic [RW-1:0] row_now, row_next;
  logic [PW-1:0] cell_position, cell_position_next;
  logic          scroll;

  tccw_pkg::result_t out_data;
  logic              out_valid;
  logic              accept;
  logic              is_write;

  assign item.ready   = !out_valid || result.ready;
  assign accept       = item.valid && item.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Printable characters write a cell
  assign is_write = item.data.operation == tccw_pkg::OP_PUT_CHAR
                    && item.data.character != tccw_pkg::CHAR_NEWLINE
                    && item.data.character != tccw_pkg::CHAR_TAB;

  // Next cursor position
  always_comb begin
    logic [CW-1:0]  col_sat;
    logic [RW-1:0]  row_sat;
    logic [RW:0]    row_inc;
    logic [CSW-1:0] col_sum;
    logic [RW:0]    row_sum;
    logic [PW:0]    pos_tab;
    col_sat            = '0;
    row_sat            = '0;
    row_inc            = {1'b0, row_now} + (RW+1)'(1);
    col_sum            = CSW'(column_now) + CSW'(TAB);
    row_sum            = {1'b0, row_now};
    pos_tab            = {1'b0, cell_position} + (PW+1)'(TAB);
    column_next        = column_now;
    row_next           = row_now;
    cell_position_next = cell_position;
    scroll             = 1'b0;

    // tab wrap: at most WRAPS row steps
    for (int i = 0; i < WRAPS; i++) begin
      if (col_sum >= CSW'(COLS)) begin
        col_sum = col_sum - CSW'(COLS);
        row_sum = row_sum + (RW+1)'(1);
      end
    end

    if (item.data.operation == tccw_pkg::OP_SET_CURSOR) begin
      // saturating set
      if (32'(item.data.new_column) > 32'(COLS - 1)) col_sat = CW'(COLS - 1);
      else col_sat = CW'(item.data.new_column);
      if (32'(item.data.new_row) > 32'(ROWS - 1)) row_sat = RW'(ROWS - 1);
      else row_sat = RW'(item.data.new_row);
      column_next        = col_sat;
      row_next           = row_sat;
      cell_position_next = PW'(32'(row_sat) * 32'(COLS)) + PW'(col_sat);
    end else if (item.data.character == tccw_pkg::CHAR_NEWLINE) begin
      if (row_inc >= (RW+1)'(ROWS)) begin
        scroll = 1'b1;
      end else begin
        column_next        = '0;
        row_next           = RW'(row_inc);
        cell_position_next = cell_position - PW'(column_now) + PW'(COLS);
      end
    end else if (item.data.character == tccw_pkg::CHAR_TAB) begin
      if (row_sum >= (RW+1)'(ROWS)) begin
        scroll = 1'b1;
      end else begin
        column_next        = CW'(col_sum);
        row_next           = RW'(row_sum);
        cell_position_next = PW'(pos_tab);
      end
    end else begin
      // printable: step one cell, wrap at line end
      cell_position_next = cell_position + PW'(1);
      if (column_now == CW'(COLS - 1)) begin
        column_next = '0;
        if (row_inc >= (RW+1)'(ROWS)) scroll = 1'b1;
        else row_next = RW'(row_inc);
      end else begin
        column_next = column_now + CW'(1);
      end
    end

    // screen end: park at start of last row
    if (scroll) begin
      column_next        = '0;
      row_next           = RW'(ROWS - 1);
      cell_position_next = PW'(LAST_START);
    end
  end

  // Cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_now    <= '0;
      row_now       <= '0;
      cell_position <= '0;
    end else if (accept) begin
      column_now    <= column_next;
      row_now       <= row_next;
      cell_position <= cell_position_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.write_enable   <= is_write;
      out_data.cell_address   <= is_write ? 11'(cell_position) : 11'd0;
      out_data.cell_value     <= is_write ? {item.data.attribute, item.data.character}
                                          : 16'd0;
      out_data.scroll_request <= scroll;
      out_data.cursor_column  <= 7'(column_next);
      out_data.cursor_row     <= 5'(row_next);
    end
  end

endmodule

FILE: src/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker: port-level assertions for the text console cursor writer
// Watches the request and result channels and is bound to text_console_cursor_writer.
// ----------------------------------------------------------------------------
module tccw_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input tccw_pkg::result_t result_data
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

  // every accepted request shows a result next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted request gave no result");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // a scroll always parks the cursor at column zero
  a_scroll: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.scroll_request |-> result_data.cursor_column == 7'd0)
    else $error("scroll with nonzero column");

  // no write means zero address and value
  a_nowrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.write_enable
      |-> result_data.cell_address == 11'd0 && result_data.cell_value == 16'd0)
    else $error("idle write fields not zero");

endmodule

bind text_console_cursor_writer tccw_checker u_tccw_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
